>>> hdl/dtsp_pkg.sv
package dtsp_pkg;

    localparam int ANGLE_W   = 15;
    localparam int AXIS_W    = 16;
    localparam int FOV_W     = 14;
    localparam int OUT_W     = 16;
    localparam int TRIG_W    = 32;
    localparam int PROD_W    = 48;
    localparam int DOT_W     = 36;
    localparam int SCALE_W   = 16;
    localparam int A_W       = DOT_W + SCALE_W;
    localparam int SPLIT_W   = 26;
    localparam int PART_W    = SPLIT_W + TRIG_W;
    localparam int NUM_W     = A_W + TRIG_W;
    localparam int DEN_W     = 64;
    localparam int QUOT_W    = 16;
    localparam int DIV_LAT   = QUOT_W + 1;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [FOV_W-1:0] HFOV_RESET = 14'd5120;
    localparam logic [FOV_W-1:0] VFOV_RESET = 14'd4134;

    localparam logic CFG_HFOV = 1'b0;
    localparam logic CFG_VFOV = 1'b1;

    localparam int ANG_HALF  = 11520;
    localparam int ANG_FULL  = 23040;
    localparam int DEG90     = 377487360;
    localparam int DEG180    = 754974720;
    localparam int CORDIC_X0 = 652032874;

    localparam int ATAN_N = 24;
    localparam int ATAN_TABLE [ATAN_N] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic signed [AXIS_W-1:0] forward_axis_x;
        logic signed [AXIS_W-1:0] forward_axis_y;
        logic signed [AXIS_W-1:0] forward_axis_z;
        logic signed [AXIS_W-1:0] right_axis_x;
        logic signed [AXIS_W-1:0] right_axis_y;
        logic signed [AXIS_W-1:0] right_axis_z;
        logic signed [AXIS_W-1:0] up_axis_x;
        logic signed [AXIS_W-1:0] up_axis_y;
        logic signed [AXIS_W-1:0] up_axis_z;
    } t_axes;

    typedef struct packed {
        logic signed [15:0]       pitch_angle;
        logic signed [15:0]       yaw_angle;
        logic signed [AXIS_W-1:0] forward_axis_x;
        logic signed [AXIS_W-1:0] forward_axis_y;
        logic signed [AXIS_W-1:0] forward_axis_z;
        logic signed [AXIS_W-1:0] right_axis_x;
        logic signed [AXIS_W-1:0] right_axis_y;
        logic signed [AXIS_W-1:0] right_axis_z;
        logic signed [AXIS_W-1:0] up_axis_x;
        logic signed [AXIS_W-1:0] up_axis_y;
        logic signed [AXIS_W-1:0] up_axis_z;
    } t_item;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        t_axes                     axes;
    } t_work;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    in_front;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic [FOV_W-1:0] horizontal_fov;
        logic [FOV_W-1:0] vertical_fov;
    } t_cfg;

    typedef struct packed {
        logic gate;
        logic neg_x;
        logic neg_y;
        logic nz_x;
        logic nz_y;
    } t_flags;

endpackage

>>> hdl/dtsp_fifo.sv
module dtsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

>>> hdl/dtsp_front.sv
module dtsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  dtsp_pkg::t_item i_item,
    output logic            o_valid,
    output dtsp_pkg::t_work o_work,
    input  logic            i_ready
);
    import dtsp_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  take;

    function automatic logic signed [ANGLE_W-1:0] wrap(input logic signed [15:0] a);
        logic signed [16:0] v;
        v = 17'(a);
        if (v > 17'(ANG_HALF)) begin
            v = v - 17'(ANG_FULL);
        end else if (v <= -17'(ANG_HALF)) begin
            v = v + 17'(ANG_FULL);
        end
        return v[ANGLE_W-1:0];
    endfunction

    always_comb begin
        n_work.pitch               = wrap(i_item.pitch_angle);
        n_work.yaw                 = wrap(i_item.yaw_angle);
        n_work.axes.forward_axis_x = i_item.forward_axis_x;
        n_work.axes.forward_axis_y = i_item.forward_axis_y;
        n_work.axes.forward_axis_z = i_item.forward_axis_z;
        n_work.axes.right_axis_x   = i_item.right_axis_x;
        n_work.axes.right_axis_y   = i_item.right_axis_y;
        n_work.axes.right_axis_z   = i_item.right_axis_z;
        n_work.axes.up_axis_x      = i_item.up_axis_x;
        n_work.axes.up_axis_y      = i_item.up_axis_y;
        n_work.axes.up_axis_z      = i_item.up_axis_z;
    end

    assign o_full = r_valid && !i_ready;
    assign take   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
endmodule

>>> hdl/dtsp_cordic.sv
module dtsp_cordic #(
    parameter int STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [31:0]                 i_angle,
    output logic signed [dtsp_pkg::TRIG_W-1:0] o_cos,
    output logic signed [dtsp_pkg::TRIG_W-1:0] o_sin
);
    import dtsp_pkg::*;

    localparam int ZW = 33;
    localparam int XW = 34;

    logic signed [ZW-1:0]     r_z    [STAGES];
    logic signed [XW-1:0]     r_x    [STAGES+1];
    logic signed [XW-1:0]     r_y    [STAGES+1];
    logic                     r_flip [STAGES+1];
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [ZW-1:0]     z_in;
    logic signed [ZW-1:0]     n_z;
    logic                     n_flip;

    // fold into [-90, 90] degrees
    always_comb begin
        z_in   = ZW'(i_angle);
        n_z    = z_in;
        n_flip = 1'b0;
        if (z_in > ZW'(DEG90)) begin
            n_z    = z_in - ZW'(DEG180);
            n_flip = 1'b1;
        end else if (z_in < -ZW'(DEG90)) begin
            n_z    = z_in + ZW'(DEG180);
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
            r_x[0]    <= XW'(CORDIC_X0);
            r_y[0]    <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TABLE[i]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                end
            end
        end
        if (i + 1 < STAGES) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i+1] <= (r_z[i] >= 0) ? r_z[i] - ATAN_I : r_z[i] + ATAN_I;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[STAGES] ? TRIG_W'(-r_x[STAGES]) : TRIG_W'(r_x[STAGES]);
            r_sin <= r_flip[STAGES] ? TRIG_W'(-r_y[STAGES]) : TRIG_W'(r_y[STAGES]);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

>>> hdl/dtsp_div.sv
module dtsp_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [dtsp_pkg::NUM_W-1:0]        i_num,
    input  logic [dtsp_pkg::DEN_W-1:0]        i_den,
    output logic [dtsp_pkg::QUOT_W-1:0]       o_quot,
    output logic                              o_ovf
);
    import dtsp_pkg::*;

    logic [NUM_W-1:0]  r_rem [QUOT_W];
    logic [DEN_W-1:0]  r_den [QUOT_W];
    logic [QUOT_W-1:0] r_q   [QUOT_W+1];
    logic              r_ovf [QUOT_W+1];

    // quotient of 2^16 or more: capped downstream
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >= (NUM_W'(i_den) << QUOT_W));
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        localparam int B = QUOT_W - 1 - k;
        logic [NUM_W-1:0] sub;
        logic             fits;
        assign sub  = NUM_W'(r_den[k]) << B;
        assign fits = (r_rem[k] >= sub);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= fits ? (r_q[k] | (QUOT_W'(1) << B)) : r_q[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
        if (k + 1 < QUOT_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= fits ? r_rem[k] - sub : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quot = r_q[QUOT_W];
    assign o_ovf  = r_ovf[QUOT_W];
endmodule

>>> hdl/dtsp_back.sv
module dtsp_back #(
    parameter int STAGES = 16,
    parameter int HALF_W = 320,
    parameter int HALF_H = 240
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtsp_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  dtsp_pkg::t_work   i_work,
    output logic              o_take,
    input  logic              i_out_full,
    output logic              o_push,
    output dtsp_pkg::t_result o_result
);
    import dtsp_pkg::*;

    localparam int LC = STAGES + 2;
    localparam logic [SCALE_W-1:0] SCALE_X = SCALE_W'(16 * HALF_W);
    localparam logic [SCALE_W-1:0] SCALE_Y = SCALE_W'(16 * HALF_H);
    localparam int DP_W = TRIG_W + DOT_W;

    logic en;

    logic signed [TRIG_W-1:0] cp, sp, cy, sy, hcx, hsx, hcy, hsy;

    logic  r_vc  [LC];
    t_axes r_axc [LC];

    logic                     r_v1;
    t_axes                    r_ax1;
    logic signed [TRIG_W-1:0] r_f0, r_f1, r_f2;
    logic signed [2*TRIG_W-1:0] m0, m1;

    logic                     r_v2;
    logic signed [PROD_W-1:0] r_p [9];

    logic                     r_v3;
    logic signed [DOT_W-1:0]  r_depth, r_vx, r_vy;
    logic signed [PROD_W+1:0] sum_d, sum_x, sum_y;

    logic                     gate;
    logic                     vx_neg, vy_neg;
    logic [DOT_W-1:0]         vx_mag, vy_mag, depth_u;
    logic [TRIG_W-1:0]        hcx_mag, hsx_mag, hcy_mag, hsy_mag;
    logic [DP_W-1:0]          dp_x, dp_y;

    logic                     r_v4;
    t_flags                   r_fl4;
    logic [A_W-1:0]           r_a_x, r_a_y;
    logic [TRIG_W-1:0]        r_c_x, r_c_y;
    logic [DEN_W-1:0]         r_d4_x, r_d4_y;

    logic                     r_v5;
    t_flags                   r_fl5;
    logic [PART_W-1:0]        r_pl_x, r_ph_x, r_pl_y, r_ph_y;
    logic [DEN_W-1:0]         r_d5_x, r_d5_y;

    logic [NUM_W-1:0]         num_x, num_y;
    t_flags                   fl6;

    logic                     r_vd  [DIV_LAT];
    t_flags                   r_fld [DIV_LAT];
    logic [QUOT_W-1:0]        q_x, q_y;
    logic                     ovf_x, ovf_y;
    logic [OUT_W:0]           fin_x, fin_y;

    assign en     = !i_out_full;
    assign o_take = en && i_valid;

    dtsp_cordic #(.STAGES(STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en),
        .i_angle({i_work.pitch[ANGLE_W-1], i_work.pitch, 16'b0}),
        .o_cos(cp), .o_sin(sp)
    );
    dtsp_cordic #(.STAGES(STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(en),
        .i_angle({i_work.yaw[ANGLE_W-1], i_work.yaw, 16'b0}),
        .o_cos(cy), .o_sin(sy)
    );

    // fov half angles settle long before an item reaches them
    dtsp_cordic #(.STAGES(STAGES)) u_hfov (
        .i_clk(i_clk), .i_en(1'b1),
        .i_angle({3'b0, i_cfg.horizontal_fov, 15'b0}),
        .o_cos(hcx), .o_sin(hsx)
    );
    dtsp_cordic #(.STAGES(STAGES)) u_vfov (
        .i_clk(i_clk), .i_en(1'b1),
        .i_angle({3'b0, i_cfg.vertical_fov, 15'b0}),
        .o_cos(hcy), .o_sin(hsy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LC; i++) begin
                r_vc[i] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else if (en) begin
            r_vc[0] <= i_valid;
            for (int i = 1; i < LC; i++) begin
                r_vc[i] <= r_vc[i-1];
            end
            r_v1    <= r_vc[LC-1];
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_vd[0] <= r_v5;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    // direction vector
    assign m0 = cp * cy;
    assign m1 = cp * sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_axc[0] <= i_work.axes;
            for (int i = 1; i < LC; i++) begin
                r_axc[i] <= r_axc[i-1];
            end
            r_ax1 <= r_axc[LC-1];
            r_f0  <= TRIG_W'(m0 >>> 30);
            r_f1  <= TRIG_W'(m1 >>> 30);
            r_f2  <= -sp;
        end
    end

    // dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= r_ax1.forward_axis_x * r_f0;
            r_p[1] <= r_ax1.forward_axis_y * r_f1;
            r_p[2] <= r_ax1.forward_axis_z * r_f2;
            r_p[3] <= r_ax1.right_axis_x * r_f0;
            r_p[4] <= r_ax1.right_axis_y * r_f1;
            r_p[5] <= r_ax1.right_axis_z * r_f2;
            r_p[6] <= r_ax1.up_axis_x * r_f0;
            r_p[7] <= r_ax1.up_axis_y * r_f1;
            r_p[8] <= r_ax1.up_axis_z * r_f2;
        end
    end

    assign sum_d = (PROD_W+2)'(r_p[0]) + (PROD_W+2)'(r_p[1]) + (PROD_W+2)'(r_p[2]);
    assign sum_x = (PROD_W+2)'(r_p[3]) + (PROD_W+2)'(r_p[4]) + (PROD_W+2)'(r_p[5]);
    assign sum_y = (PROD_W+2)'(r_p[6]) + (PROD_W+2)'(r_p[7]) + (PROD_W+2)'(r_p[8]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_depth <= sum_d[PROD_W+1:14];
            r_vx    <= sum_x[PROD_W+1:14];
            r_vy    <= sum_y[PROD_W+1:14];
        end
    end

    // gate, magnitudes, first products
    always_comb begin
        gate    = !r_depth[DOT_W-1] && (r_depth != '0) &&
                  (i_cfg.horizontal_fov != '0) && (i_cfg.vertical_fov != '0);
        vx_neg  = r_vx[DOT_W-1];
        vy_neg  = r_vy[DOT_W-1];
        vx_mag  = vx_neg ? DOT_W'(-r_vx) : DOT_W'(r_vx);
        vy_mag  = vy_neg ? DOT_W'(-r_vy) : DOT_W'(r_vy);
        depth_u = DOT_W'(r_depth);
        hcx_mag = hcx[TRIG_W-1] ? TRIG_W'(-hcx) : TRIG_W'(hcx);
        hsx_mag = hsx[TRIG_W-1] ? TRIG_W'(-hsx) : TRIG_W'(hsx);
        hcy_mag = hcy[TRIG_W-1] ? TRIG_W'(-hcy) : TRIG_W'(hcy);
        hsy_mag = hsy[TRIG_W-1] ? TRIG_W'(-hsy) : TRIG_W'(hsy);
        dp_x    = DP_W'(hsx_mag) * DP_W'(depth_u);
        dp_y    = DP_W'(hsy_mag) * DP_W'(depth_u);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl4.gate  <= gate;
            r_fl4.neg_x <= !(vx_neg ^ hcx[TRIG_W-1] ^ hsx[TRIG_W-1]);
            r_fl4.neg_y <= !(vy_neg ^ hcy[TRIG_W-1] ^ hsy[TRIG_W-1]);
            r_fl4.nz_x  <= 1'b0;
            r_fl4.nz_y  <= 1'b0;
            r_a_x       <= A_W'(vx_mag) * A_W'(SCALE_X);
            r_a_y       <= A_W'(vy_mag) * A_W'(SCALE_Y);
            r_c_x       <= hcx_mag;
            r_c_y       <= hcy_mag;
            r_d4_x      <= dp_x[DEN_W-1:0];
            r_d4_y      <= dp_y[DEN_W-1:0];
        end
    end

    // numerator partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl5  <= r_fl4;
            r_pl_x <= PART_W'(r_a_x[SPLIT_W-1:0]) * PART_W'(r_c_x);
            r_ph_x <= PART_W'(r_a_x[A_W-1:SPLIT_W]) * PART_W'(r_c_x);
            r_pl_y <= PART_W'(r_a_y[SPLIT_W-1:0]) * PART_W'(r_c_y);
            r_ph_y <= PART_W'(r_a_y[A_W-1:SPLIT_W]) * PART_W'(r_c_y);
            r_d5_x <= r_d4_x;
            r_d5_y <= r_d4_y;
        end
    end

    always_comb begin
        num_x     = (NUM_W'(r_ph_x) << SPLIT_W) + NUM_W'(r_pl_x);
        num_y     = (NUM_W'(r_ph_y) << SPLIT_W) + NUM_W'(r_pl_y);
        fl6       = r_fl5;
        fl6.nz_x  = (num_x != '0);
        fl6.nz_y  = (num_y != '0);
    end

    dtsp_div u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(num_x), .i_den(r_d5_x),
        .o_quot(q_x), .o_ovf(ovf_x)
    );
    dtsp_div u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(num_y), .i_den(r_d5_y),
        .o_quot(q_y), .o_ovf(ovf_y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fld[0] <= fl6;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_fld[i] <= r_fld[i-1];
            end
        end
    end

    // {saturated, offset}
    function automatic logic [OUT_W:0] finish(
        input logic [QUOT_W-1:0] q,
        input logic              ovf,
        input logic              neg,
        input logic              nz
    );
        logic [OUT_W:0] r;
        if (!nz) begin
            r = '0;
        end else if (neg) begin
            if (ovf || (q > 16'd32768)) begin
                r = {1'b1, 16'h8000};
            end else begin
                r = {1'b0, OUT_W'(-q)};
            end
        end else begin
            if (ovf || q[QUOT_W-1]) begin
                r = {1'b1, 16'h7fff};
            end else begin
                r = {1'b0, OUT_W'(q)};
            end
        end
        return r;
    endfunction

    always_comb begin
        fin_x = finish(q_x, ovf_x, r_fld[DIV_LAT-1].neg_x, r_fld[DIV_LAT-1].nz_x);
        fin_y = finish(q_y, ovf_y, r_fld[DIV_LAT-1].neg_y, r_fld[DIV_LAT-1].nz_y);
        o_result = '0;
        if (r_fld[DIV_LAT-1].gate) begin
            o_result.screen_x  = fin_x[OUT_W-1:0];
            o_result.screen_y  = fin_y[OUT_W-1:0];
            o_result.in_front  = 1'b1;
            o_result.saturated = fin_x[OUT_W] || fin_y[OUT_W];
        end
    end

    assign o_push = en && r_vd[DIV_LAT-1];
endmodule

>>> hdl/direction_to_screen_projector_unit.sv
// channel   direction  handshake                 payload
// input     in         push / full               i_item   (dtsp_pkg::t_item)
// result    out        empty / pop               o_result (dtsp_pkg::t_result)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per cycle in and out while neither queue is full; the path to the result
// ports runs through the angle cordic pipelines and the 17-stage quotient
// pipeline
// reset is synchronous; fov registers come up at 5120 and 4134
// the pipeline holds while the result queue is full; a short queue between
// the angle stage and the pipeline absorbs stalls on either side
module direction_to_screen_projector_unit #(
    parameter int CORDIC_STAGES      = 16,
    parameter int SCREEN_HALF_WIDTH  = 320,
    parameter int SCREEN_HALF_HEIGHT = 240
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  dtsp_pkg::t_item                i_item,
    output logic                           empty,
    input  logic                           pop,
    output dtsp_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [dtsp_pkg::FOV_W-1:0]     i_cfg_data
);
    import dtsp_pkg::*;

    t_cfg    r_cfg;
    logic    front_valid;
    t_work   front_work;
    logic    mid_full;
    logic    mid_empty;
    t_work   mid_work;
    logic    mid_pop;
    logic    out_full;
    logic    out_push;
    t_result back_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.horizontal_fov <= HFOV_RESET;
            r_cfg.vertical_fov   <= VFOV_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HFOV: r_cfg.horizontal_fov <= i_cfg_data;
                CFG_VFOV: r_cfg.vertical_fov   <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    dtsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full), .i_item(i_item),
        .o_valid(front_valid), .o_work(front_work), .i_ready(!mid_full)
    );

    dtsp_fifo #(.WIDTH($bits(t_work)), .DEPTH(MID_DEPTH)) u_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(front_valid && !mid_full), .i_data(front_work), .o_full(mid_full),
        .i_pop(mid_pop), .o_data(mid_work), .o_empty(mid_empty)
    );

    dtsp_back #(
        .STAGES(CORDIC_STAGES), .HALF_W(SCREEN_HALF_WIDTH), .HALF_H(SCREEN_HALF_HEIGHT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(!mid_empty), .i_work(mid_work), .o_take(mid_pop),
        .i_out_full(out_full), .o_push(out_push), .o_result(back_result)
    );

    dtsp_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(out_push), .i_data(back_result), .o_full(out_full),
        .i_pop(pop && !empty), .o_data(o_result), .o_empty(empty)
    );

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.in_front) |->
        (o_result.screen_x == 0 && o_result.screen_y == 0 && !o_result.saturated))
        else $error("gated word carries a nonzero offset");

    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (mid_full && front_valid))
        else $error("input stalled with room in the queue");
`endif
endmodule
